// ===== src/id3tfp_pkg.sv =====
// shared types, codes and frame id helpers for the id3v2 text frame parser
package id3tfp_pkg;

  // parser phase codes
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_SIZE    = 3'd2;
  localparam logic [2:0] PH_FLAGS   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  // result event codes
  localparam logic [1:0] EV_TEXT     = 2'd0;
  localparam logic [1:0] EV_TEXT_END = 2'd1;
  localparam logic [1:0] EV_BAD_ENC  = 2'd2;
  localparam logic [1:0] EV_TAG_END  = 2'd3;

  // text encoding codes
  localparam logic [7:0] ENC_LATIN1  = 8'd0;
  localparam logic [7:0] ENC_UTF16   = 8'd1;
  localparam logic [7:0] ENC_UTF8    = 8'd3;

  // header and frame layout
  localparam logic [3:0] HDR_LEN       = 4'd10;
  localparam logic [3:0] HDR_SIZE_POS  = 4'd6;
  localparam logic [3:0] ID_LEN        = 4'd4;
  localparam logic [3:0] SIZE_LEN      = 4'd4;
  localparam logic [3:0] FLAGS_LEN     = 4'd2;
  localparam logic [33:0] FRAME_HDR_LEN = 34'd10;

  // wanted frame ids
  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TYER = 32'h5459_4552;
  localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
  localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

  // frame kind codes
  localparam logic [2:0] KIND_TITLE   = 3'd0;
  localparam logic [2:0] KIND_ALBUM   = 3'd1;
  localparam logic [2:0] KIND_ARTIST  = 3'd2;
  localparam logic [2:0] KIND_YEAR    = 3'd3;
  localparam logic [2:0] KIND_GENRE   = 3'd4;
  localparam logic [2:0] KIND_COMMENT = 3'd5;

  // result queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_PUSH    = 3;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] value;
    logic [2:0] frame_kind;
  } id3tfp_result_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0]                    count;
    id3tfp_result_t [MAX_PUSH-1:0] item;
  } id3tfp_push_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
  } id3tfp_id_match_t;

  function automatic logic enc_supported(input logic [7:0] enc);
    return (enc == ENC_LATIN1) || (enc == ENC_UTF16) || (enc == ENC_UTF8);
  endfunction

  function automatic id3tfp_id_match_t id_lookup(input logic [31:0] ident);
    id3tfp_id_match_t m;
    m.hit  = 1'b1;
    m.kind = KIND_TITLE;
    unique case (ident)
      ID_TIT2: m.kind = KIND_TITLE;
      ID_TALB: m.kind = KIND_ALBUM;
      ID_TPE1: m.kind = KIND_ARTIST;
      ID_TYER: m.kind = KIND_YEAR;
      ID_TCON: m.kind = KIND_GENRE;
      ID_COMM: m.kind = KIND_COMMENT;
      default: m.hit  = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== src/id3tfp_ifs.sv =====
// byte stream and result stream channel interfaces
interface id3tfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface id3tfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] value;
  logic [2:0] frame_kind;

  modport source (output valid, output event_res, output value, output frame_kind,
                  input ready);
  modport sink   (input valid, input event_res, input value, input frame_kind,
                  output ready);
endinterface

// ===== src/id3tfp_result_queue.sv =====
// small result queue that takes up to three results a cycle and hands out one
module id3tfp_result_queue
  import id3tfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  id3tfp_push_t       push,
  output logic               room,
  id3tfp_out_if.source       result
);

  id3tfp_result_t q [QUEUE_DEPTH];
  id3tfp_result_t q_next [QUEUE_DEPTH];
  logic [2:0]     count;
  logic [2:0]     count_next;
  logic [2:0]     base;
  logic [2:0]     slot;
  logic           pop;

  assign pop  = result.valid && result.ready;
  // room for a full burst of results without looking at the sink side
  assign room = (count <= 3'(QUEUE_DEPTH - MAX_PUSH));

  // head of the queue drives the result channel
  assign result.valid      = (count != 3'd0);
  assign result.event_res  = q[0].event_res;
  assign result.value      = q[0].value;
  assign result.frame_kind = q[0].frame_kind;

  // shift out on a pop, then append the new results behind what remains
  always_comb begin
    slot = 3'd0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    base = count - {2'b00, pop};
    for (int j = 0; j < MAX_PUSH; j++) begin
      slot = base + 3'(j);
      if (2'(j) < push.count) begin
        q_next[slot[1:0]] = push.item[j];
      end
    end
    count_next = base + {1'b0, push.count};
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QUEUE_DEPTH))
    else $error("result queue over depth");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |->
      ({1'b0, count} - {3'b000, pop} + {2'b00, push.count} <= 4'(QUEUE_DEPTH)))
    else $error("result queue push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> (count == $past(count) - 3'd1))
    else $error("result queue count wrong after pop");

  a_hold_no_pop: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready && push.count == 2'd0)
      |=> (count == $past(count)))
    else $error("result queue count moved while stalled");
`endif

endmodule

// ===== src/id3v2_text_frame_parser_core.sv =====
// id3v2.3 tag parser that emits the text of title, album, artist, year, genre and comment frames
// The block takes one tag byte per request on the stream channel and accepts a byte in every
// cycle that the queue has room; each byte is decoded combinationally from the parser state
// registers and causes zero to three results (text character, end of frame text, unsupported
// encoding, end of tag) that go into a four-entry result queue. The stream side stays ready
// while that queue holds at most one result, so with one result or less per byte and a ready
// result channel the sustained rate is one byte per cycle; the results of a byte that yields
// several leave one per cycle while the sink is ready. A request with restart set starts a new
// tag at that byte; after the end of a tag, bytes are taken and dropped until the next restart.
module id3v2_text_frame_parser_core
  import id3tfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  id3tfp_in_if.sink     stream,
  id3tfp_out_if.source  result
);

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  phase_count;
    logic [27:0] tag_size;
    logic [33:0] bytes_consumed;
    logic [31:0] frame_ident;
    logic [31:0] frame_length;
    logic [31:0] payload_index;
    logic [7:0]  text_encoding;
    logic        frame_wanted;
    logic [2:0]  kind_code;
    logic        text_stopped;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_HEADER, phase_count: 4'd0, tag_size: 28'd0, bytes_consumed: 34'd0,
    frame_ident: 32'd0, frame_length: 32'd0, payload_index: 32'd0,
    text_encoding: 8'd0, frame_wanted: 1'b0, kind_code: 3'd0, text_stopped: 1'b0};

  parse_state_t     st;
  parse_state_t     cur;
  parse_state_t     st_next;
  logic             accept;
  logic             room;
  logic [7:0]       b;
  logic [3:0]       count_inc;
  logic [32:0]      index_inc;
  logic [33:0]      consumed_sum;
  logic             finish;
  id3tfp_id_match_t id_match;
  id3tfp_result_t   cand [MAX_PUSH];
  logic [2:0]       cand_v;
  id3tfp_push_t     push;
  logic [1:0]       n;

  assign stream.ready = room;
  assign accept       = stream.valid && stream.ready;
  assign b            = stream.data_byte;
  assign cur          = stream.restart ? STATE_RESET : st;

  // one byte step of the parser
  always_comb begin
    st_next      = cur;
    finish       = 1'b0;
    cand_v       = 3'b000;
    count_inc    = cur.phase_count + 4'd1;
    index_inc    = {1'b0, cur.payload_index} + 33'd1;
    consumed_sum = 34'd0;
    id_match     = id_lookup({cur.frame_ident[23:0], b});
    cand[0]      = '{event_res: EV_TEXT, value: b, frame_kind: cur.kind_code};
    cand[1]      = '{event_res: EV_TEXT_END, value: 8'd0, frame_kind: cur.kind_code};
    cand[2]      = '{event_res: EV_TAG_END, value: 8'd0, frame_kind: KIND_TITLE};
    unique case (cur.phase)
      PH_HEADER: begin
        if (cur.phase_count >= HDR_SIZE_POS) begin
          st_next.tag_size = {cur.tag_size[20:0], b[6:0]};
        end
        st_next.phase_count = count_inc;
        if (count_inc >= HDR_LEN) begin
          st_next.bytes_consumed = 34'd0;
          st_next.phase_count    = 4'd0;
          if (st_next.tag_size == 28'd0) begin
            cand_v[2]     = 1'b1;
            st_next.phase = PH_DONE;
          end else begin
            st_next.phase = PH_ID;
          end
        end
      end
      PH_ID: begin
        if (cur.phase_count == 4'd0 && b == 8'd0) begin
          // padding: the tag ends here
          cand_v[2]     = 1'b1;
          st_next.phase = PH_DONE;
        end else begin
          st_next.frame_ident = {cur.frame_ident[23:0], b};
          st_next.phase_count = count_inc;
          if (count_inc >= ID_LEN) begin
            st_next.frame_wanted = id_match.hit;
            st_next.kind_code    = id_match.hit ? id_match.kind : KIND_TITLE;
            st_next.phase        = PH_SIZE;
            st_next.phase_count  = 4'd0;
            st_next.frame_length = 32'd0;
          end
        end
      end
      PH_SIZE: begin
        st_next.frame_length = {cur.frame_length[23:0], b};
        st_next.phase_count  = count_inc;
        if (count_inc >= SIZE_LEN) begin
          st_next.phase       = PH_FLAGS;
          st_next.phase_count = 4'd0;
        end
      end
      PH_FLAGS: begin
        st_next.phase_count = count_inc;
        if (count_inc >= FLAGS_LEN) begin
          st_next.phase_count   = 4'd0;
          st_next.payload_index = 32'd0;
          st_next.text_encoding = ENC_LATIN1;
          st_next.text_stopped  = 1'b0;
          if (cur.frame_length == 32'd0) begin
            finish = 1'b1;
          end else begin
            st_next.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (cur.frame_wanted) begin
          if (cur.payload_index == 32'd0) begin
            // encoding byte
            st_next.text_encoding = b;
            if (!enc_supported(b)) begin
              cand[0].event_res = EV_BAD_ENC;
              cand_v[0]         = 1'b1;
            end
          end else begin
            case (cur.text_encoding)
              ENC_LATIN1: cand_v[0] = (b != 8'd0);
              ENC_UTF16: begin
                cand_v[0] = (cur.payload_index >= 32'd3) && cur.payload_index[0] &&
                            (b != 8'd0);
              end
              ENC_UTF8: begin
                if (!cur.text_stopped) begin
                  if (b == 8'd0) begin
                    st_next.text_stopped = 1'b1;
                  end else begin
                    cand_v[0] = 1'b1;
                  end
                end
              end
              default: cand_v[0] = 1'b0;
            endcase
          end
        end
        st_next.payload_index = index_inc[31:0];
        if (index_inc >= {1'b0, cur.frame_length}) begin
          finish = 1'b1;
        end
      end
      default: st_next = cur;
    endcase

    // frame close: end of text, running count and tag end check
    if (finish) begin
      cand_v[1] = cur.frame_wanted && enc_supported(st_next.text_encoding);
      consumed_sum = cur.bytes_consumed + FRAME_HDR_LEN + {2'b00, cur.frame_length};
      st_next.bytes_consumed = consumed_sum;
      if (consumed_sum >= {6'd0, cur.tag_size}) begin
        cand_v[2]     = 1'b1;
        st_next.phase = PH_DONE;
      end else begin
        st_next.phase       = PH_ID;
        st_next.phase_count = 4'd0;
      end
    end
  end

  // pack the results in order
  always_comb begin
    n         = 2'd0;
    push.item = '0;
    for (int j = 0; j < MAX_PUSH; j++) begin
      if (cand_v[j]) begin
        push.item[n] = cand[j];
        n            = n + 2'd1;
      end
    end
    push.count = accept ? n : 2'd0;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  id3tfp_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

`ifndef SYNTH
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_DONE && !(stream.valid && stream.restart)) |=> (st.phase == PH_DONE))
    else $error("parser left the done phase without a restart");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !stream.restart && st.phase == PH_DONE) |-> (push.count == 2'd0))
    else $error("result produced after tag end");

  a_tag_end_moves_done: assert property (@(posedge clk) disable iff (rst)
    (accept && cand_v[2]) |=> (st.phase == PH_DONE))
    else $error("tag end without done phase");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("results pushed without queue room");
`endif

endmodule
